### rtl/core/htfd_pkg.sv
// shared types, constants and the crc-8 byte step for the sensor frame decoder
package htfd_pkg;

	localparam int RAW_W   = 20;
	localparam int HUM_W   = 14;
	localparam int TEMP_W  = 15;
	localparam int IDX_W   = 3;

	// crc-8, polynomial x^8+x^5+x^4+1, msb first, no final xor
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	// byte positions within the 7-byte frame
	localparam logic [IDX_W-1:0] BYTE_STATUS   = 3'd0;
	localparam logic [IDX_W-1:0] BYTE_HUM_HI   = 3'd1;
	localparam logic [IDX_W-1:0] BYTE_HUM_MID  = 3'd2;
	localparam logic [IDX_W-1:0] BYTE_MIXED    = 3'd3;
	localparam logic [IDX_W-1:0] BYTE_TEMP_MID = 3'd4;
	localparam logic [IDX_W-1:0] BYTE_TEMP_LO  = 3'd5;
	localparam logic [IDX_W-1:0] BYTE_CRC      = 3'd6;
	localparam logic [IDX_W-1:0] BYTE_UNUSED   = 3'd7;

	// scaling: humidity raw*10000 >> 20, temperature (raw*20000 >> 20) - 5000
	localparam logic [13:0]       HUM_SCALE   = 14'd10000;
	localparam logic [14:0]       TEMP_SCALE  = 15'd20000;
	localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd5000;

	typedef struct packed {
		logic [RAW_W-1:0] humidity_raw;
		logic [RAW_W-1:0] temperature_raw;
		logic             crc_ok;
	} frame_t;

	function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### rtl/core/htfd_ifs.sv
// valid/ready channel interfaces for frame bytes and decoded measurements
interface htfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface htfd_meas_if;
	logic                                  valid;
	logic                                  ready;
	logic [htfd_pkg::RAW_W-1:0]            humidity_raw;
	logic [htfd_pkg::RAW_W-1:0]            temperature_raw;
	logic [htfd_pkg::HUM_W-1:0]            humidity_centi;
	logic signed [htfd_pkg::TEMP_W-1:0]    temperature_centi;
	logic                                  crc_ok;

	modport source (output valid, output humidity_raw, output temperature_raw,
		output humidity_centi, output temperature_centi, output crc_ok, input ready);
	modport sink (input valid, input humidity_raw, input temperature_raw,
		input humidity_centi, input temperature_centi, input crc_ok, output ready);
endinterface

### rtl/core/humidity_temp_frame_decoder_top.sv
// humidity and temperature sensor frame decoder, top level
// Takes the sensor's 7-byte measurement frame one byte per transfer on rx
// (status, five data bytes, crc) and gives one measurement transfer on meas
// for every seventh byte: the two 20-bit raw fields, humidity in 0.01 %rh,
// temperature in 0.01 deg c and crc_ok (crc-8 0x31, init 0xff over bytes 0
// to 5 equals byte 6). frame_start on a byte restarts the count and the crc
// at that byte; without it bytes are simply counted from the last frame end.
// One byte is taken every clock cycle while rx.ready is high. A measurement
// goes from its crc byte transfer into the frame register, then through the
// scaling multipliers into the output register that drives meas. rx.ready
// drops only when both of those registers hold measurements and meas is
// stalled; bytes 0 to 5 wait on the same ready as the crc byte.
module humidity_temp_frame_decoder_top (
	input  logic               clk,
	input  logic               arst_n,
	htfd_rx_if.sink            rx,
	htfd_meas_if.source        meas
);

	// frame assembly state
	logic [htfd_pkg::IDX_W-1:0]  byte_index_q;
	logic [7:0]                  crc_q;
	logic [htfd_pkg::RAW_W-1:0]  humid_q;
	logic [htfd_pkg::RAW_W-1:0]  temp_q;

	// stage 1: assembled frame, stage 2: scaled result
	logic                        valid_s1;
	htfd_pkg::frame_t            frame_s1;
	logic                        valid_s2;
	htfd_pkg::frame_t            frame_s2;
	logic [htfd_pkg::HUM_W-1:0]  hum_centi_s2;
	logic signed [htfd_pkg::TEMP_W-1:0] temp_centi_s2;

	logic [htfd_pkg::IDX_W-1:0]  idx;
	logic [7:0]                  crc_base;
	logic [7:0]                  crc_next;
	logic                        last_byte;
	logic                        rx_xfer;
	logic                        emit;
	logic                        take_s1;
	logic [htfd_pkg::HUM_W-1:0]  hum_centi;
	logic signed [htfd_pkg::TEMP_W-1:0] temp_centi;

	// stage 2 is free or being drained this cycle
	assign take_s1  = !valid_s2 || meas.ready;
	assign rx.ready = !valid_s1 || take_s1;
	assign rx_xfer  = rx.valid && rx.ready;

	// a start flag drops any partial frame; the unused count value reads as byte 0
	always_comb begin
		idx      = rx.frame_start ? htfd_pkg::BYTE_STATUS : byte_index_q;
		crc_base = rx.frame_start ? htfd_pkg::CRC_INIT : crc_q;
		if (idx == htfd_pkg::BYTE_UNUSED) begin
			idx = htfd_pkg::BYTE_STATUS;
		end
	end

	assign last_byte = (idx == htfd_pkg::BYTE_CRC);
	assign emit      = rx_xfer && last_byte;
	assign crc_next  = htfd_pkg::crc_step(crc_base, rx.rx_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= htfd_pkg::BYTE_STATUS;
			crc_q        <= htfd_pkg::CRC_INIT;
			humid_q      <= '0;
			temp_q       <= '0;
		end else if (rx_xfer) begin
			if (last_byte) begin
				// frame done, back to the status byte
				byte_index_q <= htfd_pkg::BYTE_STATUS;
				crc_q        <= htfd_pkg::CRC_INIT;
			end else begin
				byte_index_q <= idx + 3'd1;
				crc_q        <= crc_next;
			end
			case (idx)
				htfd_pkg::BYTE_HUM_HI: begin
					humid_q <= {rx.rx_byte, 12'd0};
				end
				htfd_pkg::BYTE_HUM_MID: begin
					humid_q <= humid_q | {8'd0, rx.rx_byte, 4'd0};
				end
				htfd_pkg::BYTE_MIXED: begin
					// high nibble closes humidity, low nibble opens temperature
					humid_q <= humid_q | {16'd0, rx.rx_byte[7:4]};
					temp_q  <= {rx.rx_byte[3:0], 16'd0};
				end
				htfd_pkg::BYTE_TEMP_MID: begin
					temp_q <= temp_q | {4'd0, rx.rx_byte, 8'd0};
				end
				htfd_pkg::BYTE_TEMP_LO: begin
					temp_q <= temp_q | {12'd0, rx.rx_byte};
				end
				default: begin
				end
			endcase
		end
	end

	// stage 1 control: loaded by the crc byte, emptied into stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (emit) begin
			valid_s1 <= 1'b1;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			frame_s1.humidity_raw    <= humid_q;
			frame_s1.temperature_raw <= temp_q;
			frame_s1.crc_ok          <= (crc_base == rx.rx_byte);
		end
	end

	htfd_scale u_scale (
		.frame             (frame_s1),
		.humidity_centi    (hum_centi),
		.temperature_centi (temp_centi)
	);

	// stage 2 is the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (valid_s1 && take_s1) begin
			valid_s2 <= 1'b1;
		end else if (meas.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && take_s1) begin
			frame_s2      <= frame_s1;
			hum_centi_s2  <= hum_centi;
			temp_centi_s2 <= temp_centi;
		end
	end

	assign meas.valid             = valid_s2;
	assign meas.humidity_raw      = frame_s2.humidity_raw;
	assign meas.temperature_raw   = frame_s2.temperature_raw;
	assign meas.humidity_centi    = hum_centi_s2;
	assign meas.temperature_centi = temp_centi_s2;
	assign meas.crc_ok            = frame_s2.crc_ok;

	// the unused count value is never stored
	assert property (@(posedge clk) disable iff (!arst_n)
		byte_index_q != htfd_pkg::BYTE_UNUSED)
		else $error("byte count reached unused value");

	// a crc byte fills stage 1 and restarts the frame state
	assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> valid_s1 && byte_index_q == htfd_pkg::BYTE_STATUS
			&& crc_q == htfd_pkg::CRC_INIT)
		else $error("crc byte did not close the frame");

	// a start-flagged byte is always taken as the status byte
	assert property (@(posedge clk) disable iff (!arst_n)
		rx_xfer && rx.frame_start |=> byte_index_q == htfd_pkg::BYTE_HUM_HI)
		else $error("start flag did not restart the count");

	// a held frame is never dropped while the output stage is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !take_s1 |=> valid_s1 && $stable(frame_s1))
		else $error("stage 1 frame lost under stall");

	// a crc byte is never accepted while stage 1 cannot move on
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !take_s1 |-> !emit)
		else $error("crc byte accepted over a stalled frame");

endmodule

### rtl/core/htfd_scale.sv
// constant-multiply scaling of the raw fields to hundredths of %rh and deg c
module htfd_scale (
	input  htfd_pkg::frame_t                   frame,
	output logic [htfd_pkg::HUM_W-1:0]         humidity_centi,
	output logic signed [htfd_pkg::TEMP_W-1:0] temperature_centi
);

	localparam int HUM_PROD_W  = htfd_pkg::RAW_W + 14;
	localparam int TEMP_PROD_W = htfd_pkg::RAW_W + 15;

	logic [HUM_PROD_W-1:0]        hum_prod;
	logic [TEMP_PROD_W-1:0]       temp_prod;
	logic [htfd_pkg::TEMP_W-1:0]  temp_scaled;

	assign hum_prod  = HUM_PROD_W'(frame.humidity_raw) * HUM_PROD_W'(htfd_pkg::HUM_SCALE);
	assign temp_prod = TEMP_PROD_W'(frame.temperature_raw) * TEMP_PROD_W'(htfd_pkg::TEMP_SCALE);

	// drop the 2^20 fraction, result below 10000 and 20000
	assign humidity_centi = hum_prod[HUM_PROD_W-1 -: htfd_pkg::HUM_W];
	assign temp_scaled    = temp_prod[TEMP_PROD_W-1 -: htfd_pkg::TEMP_W];

	assign temperature_centi = $signed(temp_scaled - htfd_pkg::TEMP_OFFSET);

endmodule
